/* src/assert_macros.svh */
// Assertion helpers shared by the scheduler RTL.
// In synthesis builds the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MRR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MRR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MRR_ASSERT(lbl, clk, rst_n, prop, msg)
`define MRR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* src/mrr_pkg.sv */
package mrr_pkg;

  localparam int MRR_NUM_TASKS       = 32;
  localparam int MRR_NUM_LEVELS      = 8;
  localparam int MRR_TASKS_PER_LEVEL = 32;

  typedef enum logic [1:0] {
    OP_RUN   = 2'd0,
    OP_SLEEP = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREV,
    ST_CAP,
    ST_DECODE,
    ST_RM_RD,
    ST_RM_CMP,
    ST_RM_UPD,
    ST_SH_RD,
    ST_SH_WR,
    ST_RM_DONE,
    ST_ADD,
    ST_TWRITE,
    ST_TICK,
    ST_PICK,
    ST_NOW,
    ST_SL_RD,
    ST_REPORT
  } state_t;

  typedef enum logic [1:0] {
    LR_NOW,
    LR_IDX,
    LR_IDX1
  } lrd_sel_t;

  typedef struct packed {
    logic     clr;
    logic     load;
    logic     lrd_en;
    lrd_sel_t lrd_sel;
    logic     use_cur;
    logic     trd_now;
    logic     prev_cap;
    logic     info_cap;
    logic     i_clr;
    logic     i_inc;
    logic     wl_load;
    logic     wl_new;
    logic     rm_upd;
    logic     sh_wr;
    logic     add;
    logic     twrite;
    logic     set_pending;
    logic     pick;
    logic     tick_adv;
    logic     out_load;
  } mrr_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       t_ok;
    logic       running;
    logic       need_rm;
    logic       match;
    logic       scan_end;
    logic       n_zero;
    logic       sh_done;
    logic       prev_is_t;
    logic       pending;
    logic       clr_last;
    logic       out_busy;
  } mrr_sts_t;

endpackage

/* src/mrr_in_if.sv */
interface mrr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [4:0] task_id;
  logic [2:0] new_level;
  logic       keep_level;
  logic [7:0] slice_ticks;

  modport source (output valid, output operation, output task_id, output new_level,
                  output keep_level, output slice_ticks, input ready);
  modport sink (input valid, input operation, input task_id, input new_level,
                input keep_level, input slice_ticks, output ready);
endinterface

/* src/mrr_out_if.sv */
interface mrr_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [4:0] current_task;
  logic [7:0] time_slice;
  logic       dispatch;

  modport source (output valid, output status, output current_task, output time_slice,
                  output dispatch, input ready);
  modport sink (input valid, input status, input current_task, input time_slice,
                input dispatch, output ready);
endinterface

/* src/multilevel_round_robin_scheduler.sv */
// The result is loaded in REPORT, once the output is free, after NOW and SL_RD; a tick
// first passes TICK, and PICK when a level pick is pending. A removal scans in RM_RD and
// RM_CMP, updates in RM_UPD, shifts in SH_RD and SH_WR and closes in RM_DONE; a run that
// lists the task anew appends it in ADD. One operation at a time: in_ch.ready rises in
// the cycle after the result is loaded. Reset: synchronous, active low; a clearing pass
// over all NUM_TASKS entries loads the task table and start lists, with in_ch.ready low.
module multilevel_round_robin_scheduler import mrr_pkg::*; #(
  parameter int NUM_TASKS       = MRR_NUM_TASKS,
  parameter int NUM_LEVELS      = MRR_NUM_LEVELS,
  parameter int TASKS_PER_LEVEL = MRR_TASKS_PER_LEVEL
) (
  input logic       clk,
  input logic       rst_n,
  mrr_in_if.sink    in_ch,
  mrr_out_if.source out_ch
);

  mrr_cmd_t cmd;
  mrr_sts_t sts;
  logic     in_ready;

  mrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrr_dp #(
    .NUM_TASKS       (NUM_TASKS),
    .NUM_LEVELS      (NUM_LEVELS),
    .TASKS_PER_LEVEL (TASKS_PER_LEVEL)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_ch.operation),
    .in_task_id       (in_ch.task_id),
    .in_new_level     (in_ch.new_level),
    .in_keep_level    (in_ch.keep_level),
    .in_slice_ticks   (in_ch.slice_ticks),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_current_task (out_ch.current_task),
    .out_time_slice   (out_ch.time_slice),
    .out_dispatch     (out_ch.dispatch)
  );

  assign in_ch.ready = in_ready;

endmodule

/* src/mrr_ctrl.sv */
`include "assert_macros.svh"

module mrr_ctrl import mrr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mrr_sts_t sts,
  output mrr_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREV;
        end
      end
      ST_PREV: begin
        // Look up the task selected before this operation.
        cmd.lrd_en  = 1'b1;
        cmd.lrd_sel = LR_NOW;
        cmd.use_cur = 1'b1;
        state_nxt   = ST_CAP;
      end
      ST_CAP: begin
        cmd.prev_cap = 1'b1;
        cmd.info_cap = 1'b1;
        state_nxt    = ST_DECODE;
      end
      ST_DECODE: begin
        cmd.i_clr   = 1'b1;
        cmd.wl_load = 1'b1;
        if (sts.op == OP_RUN && sts.t_ok) begin
          cmd.wl_new = !sts.need_rm;
          if (sts.need_rm) state_nxt = ST_RM_RD;
          else if (!sts.running) state_nxt = ST_ADD;
          else state_nxt = ST_TWRITE;
        end else if (sts.op == OP_SLEEP && sts.t_ok) begin
          state_nxt = sts.running ? ST_RM_RD : ST_NOW;
        end else if (sts.op == OP_TICK) begin
          state_nxt = ST_TICK;
        end else begin
          state_nxt = ST_NOW;
        end
      end
      ST_RM_RD: begin
        if (sts.n_zero) begin
          state_nxt = ST_RM_DONE;
        end else begin
          cmd.lrd_en  = 1'b1;
          cmd.lrd_sel = LR_IDX;
          state_nxt   = ST_RM_CMP;
        end
      end
      ST_RM_CMP: begin
        if (sts.match) begin
          state_nxt = ST_RM_UPD;
        end else if (sts.scan_end) begin
          state_nxt = ST_RM_DONE;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = ST_RM_RD;
        end
      end
      ST_RM_UPD: begin
        cmd.rm_upd = 1'b1;
        state_nxt  = ST_SH_RD;
      end
      ST_SH_RD: begin
        if (sts.sh_done) begin
          state_nxt = ST_RM_DONE;
        end else begin
          cmd.lrd_en  = 1'b1;
          cmd.lrd_sel = LR_IDX1;
          state_nxt   = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        cmd.sh_wr = 1'b1;
        cmd.i_inc = 1'b1;
        state_nxt = ST_SH_RD;
      end
      ST_RM_DONE: begin
        if (sts.op == OP_RUN) begin
          cmd.wl_load = 1'b1;
          cmd.wl_new  = 1'b1;
          state_nxt   = ST_ADD;
        end else begin
          state_nxt = ST_TWRITE;
        end
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_TWRITE;
      end
      ST_TWRITE: begin
        cmd.twrite = 1'b1;
        if (sts.op == OP_RUN) begin
          cmd.set_pending = 1'b1;
          state_nxt       = ST_NOW;
        end else if (sts.prev_is_t) begin
          state_nxt = ST_PICK;
        end else begin
          state_nxt = ST_NOW;
        end
      end
      ST_TICK: begin
        cmd.tick_adv = 1'b1;
        cmd.use_cur  = 1'b1;
        state_nxt    = sts.pending ? ST_PICK : ST_NOW;
      end
      ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = ST_NOW;
      end
      ST_NOW: begin
        cmd.lrd_en  = 1'b1;
        cmd.lrd_sel = LR_NOW;
        cmd.use_cur = 1'b1;
        state_nxt   = ST_SL_RD;
      end
      ST_SL_RD: begin
        cmd.trd_now = 1'b1;
        state_nxt   = ST_REPORT;
      end
      ST_REPORT: begin
        cmd.trd_now = 1'b1;
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  `MRR_ASSERT(a_ctrl_load_free, clk, rst_n, cmd.out_load |-> !sts.out_busy, "result overwritten")
  `MRR_ASSERT(a_ctrl_upd_match, clk, rst_n, (state_r == ST_RM_UPD) |-> $past(sts.match), "removal without match")
  `MRR_ASSERT(a_ctrl_accept, clk, rst_n, (in_valid && in_ready) |=> (state_r == ST_PREV), "accepted beat not started")

endmodule

/* src/mrr_dp.sv */
`include "assert_macros.svh"

module mrr_dp import mrr_pkg::*; #(
  parameter int NUM_TASKS       = MRR_NUM_TASKS,
  parameter int NUM_LEVELS      = MRR_NUM_LEVELS,
  parameter int TASKS_PER_LEVEL = MRR_TASKS_PER_LEVEL
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mrr_cmd_t   cmd,
  output mrr_sts_t   sts,
  input  logic [1:0] in_operation,
  input  logic [4:0] in_task_id,
  input  logic [2:0] in_new_level,
  input  logic       in_keep_level,
  input  logic [7:0] in_slice_ticks,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_status,
  output logic [4:0] out_current_task,
  output logic [7:0] out_time_slice,
  output logic       out_dispatch
);

  localparam int TW  = $clog2(NUM_TASKS);
  localparam int LW  = $clog2(NUM_LEVELS);
  localparam int CLW = $clog2(NUM_LEVELS + 1);
  localparam int CW  = $clog2(TASKS_PER_LEVEL + 1);
  localparam int PW  = $clog2(TASKS_PER_LEVEL);
  localparam int AW  = $clog2(NUM_LEVELS * TASKS_PER_LEVEL);
  localparam int LDEPTH = NUM_LEVELS * TASKS_PER_LEVEL;
  // Reset places of task 0 and the idle task in their lists.
  localparam int INIT0_ADDR = TASKS_PER_LEVEL;
  localparam int INIT1_ADDR = (NUM_LEVELS - 1) * TASKS_PER_LEVEL + ((NUM_LEVELS == 2) ? 1 : 0);

  // Latched operation.
  logic [1:0]    op_r;
  logic [TW-1:0] t_r;
  logic          t_ok_r;
  logic [2:0]    nl_r;
  logic          keep_r;
  logic [7:0]    sl_r;

  // Task table entry of t_r.
  logic          irun_r;
  logic [LW-1:0] ilvl_r;
  logic [7:0]    isl_r;

  logic [LW-1:0]  wl_r;
  logic [CW-1:0]  i_r;
  logic           add_ok_r;
  logic [CLW-1:0] cur_r;
  logic           pend_r;
  logic [TW-1:0]  prev_r;
  logic           pnone_r;
  logic [TW-1:0]  lrd_r;
  logic           nn_r;
  logic [TW-1:0]  clr_r;
  logic [CW-1:0]  cnt_r [NUM_LEVELS];
  logic [PW-1:0]  pos_r [NUM_LEVELS];

  logic           trun_m [NUM_TASKS];
  logic [LW-1:0]  tlvl_m [NUM_TASKS];
  logic [7:0]     tsl_m  [NUM_TASKS];
  logic [TW-1:0]  lmem   [LDEPTH];
  logic           trun_q;
  logic [LW-1:0]  tlvl_q;
  logic [7:0]     tsl_q;

  logic           out_valid_r;
  logic           out_status_r;
  logic [4:0]     out_task_r;
  logic [7:0]     out_slice_r;
  logic           out_disp_r;

  logic           cur_ok;
  logic [LW-1:0]  lv_sel;
  logic [CW-1:0]  cnt_s;
  logic [PW-1:0]  pos_s;
  logic [LW-1:0]  lv_sat;
  logic [LW-1:0]  lv_new;
  logic           need_rm;
  logic [AW-1:0]  base;
  logic [AW-1:0]  lra;
  logic           lwe;
  logic [AW-1:0]  lwa;
  logic [TW-1:0]  lwd;
  logic           room;
  logic           twe;
  logic [TW-1:0]  twa;
  logic           twd_run;
  logic [LW-1:0]  twd_lvl;
  logic [7:0]     twd_sl;
  logic [TW-1:0]  tra;
  logic [CW-1:0]  n1;
  logic [CW-1:0]  p0;
  logic [CW-1:0]  p1;
  logic [CW-1:0]  p2;
  logic [CW-1:0]  pinc;
  logic [CW-1:0]  ptick;
  logic [CLW-1:0] pick_lv;
  logic           same_task;
  logic           tick_disp;
  logic           disp;

  assign cur_ok  = int'(cur_r) < NUM_LEVELS;
  assign lv_sel  = cmd.use_cur ? (cur_ok ? LW'(cur_r) : '0) : wl_r;
  assign cnt_s   = cnt_r[lv_sel];
  assign pos_s   = pos_r[lv_sel];
  assign lv_sat  = (int'(nl_r) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1) : LW'(nl_r);
  assign lv_new  = keep_r ? ilvl_r : lv_sat;
  assign need_rm = irun_r && (ilvl_r != lv_new);
  assign base    = AW'(lv_sel) * AW'(TASKS_PER_LEVEL);
  assign room    = cnt_s < CW'(TASKS_PER_LEVEL);

  always_comb begin
    case (cmd.lrd_sel)
      LR_NOW:  lra = base + AW'(pos_s);
      LR_IDX:  lra = base + AW'(i_r);
      LR_IDX1: lra = base + AW'(i_r) + AW'(1);
      default: lra = base;
    endcase
  end

  always_comb begin
    lwe = 1'b0;
    lwa = base + AW'(i_r);
    lwd = lrd_r;
    if (cmd.clr) begin
      lwe = (clr_r == TW'(0)) || (clr_r == TW'(1));
      lwa = (clr_r == TW'(0)) ? AW'(INIT0_ADDR) : AW'(INIT1_ADDR);
      lwd = clr_r;
    end else if (cmd.sh_wr) begin
      lwe = 1'b1;
    end else if (cmd.add) begin
      lwe = room;
      lwa = base + AW'(cnt_s);
      lwd = t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (lwe) lmem[lwa] <= lwd;
    if (cmd.lrd_en) lrd_r <= lmem[lra];
  end

  always_comb begin
    twe     = cmd.clr || cmd.twrite;
    twa     = cmd.clr ? clr_r : t_r;
    twd_run = 1'b0;
    twd_lvl = ilvl_r;
    twd_sl  = isl_r;
    if (cmd.clr) begin
      twd_run = clr_r < TW'(2);
      twd_lvl = (clr_r == TW'(0)) ? LW'(1) :
                (clr_r == TW'(1)) ? LW'(NUM_LEVELS - 1) : '0;
      twd_sl  = (clr_r < TW'(2)) ? 8'd1 : 8'd0;
    end else if (op_r == OP_RUN) begin
      twd_run = add_ok_r || (irun_r && !need_rm);
      twd_lvl = lv_new;
      twd_sl  = (sl_r != 8'd0) ? sl_r : isl_r;
    end
  end

  assign tra = cmd.trd_now ? lrd_r : t_r;

  always_ff @(posedge clk) begin
    if (twe) begin
      trun_m[twa] <= twd_run;
      tlvl_m[twa] <= twd_lvl;
      tsl_m[twa]  <= twd_sl;
    end
    trun_q <= trun_m[tra];
    tlvl_q <= tlvl_m[tra];
    tsl_q  <= tsl_m[tra];
  end

  // Removal: the count drops and the rotating position follows the entry it pointed at.
  assign n1    = cnt_s - CW'(1);
  assign p0    = CW'(pos_s);
  assign p1    = (i_r < p0) ? (p0 - CW'(1)) : p0;
  assign p2    = (p1 >= n1) ? '0 : p1;
  assign pinc  = p0 + CW'(1);
  assign ptick = (pinc >= cnt_s) ? '0 : pinc;

  always_comb begin
    pick_lv = CLW'(NUM_LEVELS);
    for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
      if (cnt_r[k] != '0) pick_lv = CLW'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_LEVELS; k++) begin
        cnt_r[k] <= CW'(int'(k == 1) + int'(k == NUM_LEVELS - 1));
        pos_r[k] <= '0;
      end
      cur_r       <= CLW'(1);
      pend_r      <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_r <= clr_r + TW'(1);
      if (cmd.rm_upd) begin
        cnt_r[lv_sel] <= n1;
        pos_r[lv_sel] <= PW'(p2);
      end
      if (cmd.add && room) cnt_r[lv_sel] <= cnt_s + CW'(1);
      if (cmd.tick_adv && cur_ok) pos_r[lv_sel] <= PW'(ptick);
      if (cmd.set_pending) pend_r <= 1'b1;
      if (cmd.pick) begin
        cur_r  <= pick_lv;
        pend_r <= 1'b0;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_operation;
      t_ok_r   <= int'(in_task_id) < NUM_TASKS;
      t_r      <= TW'(in_task_id);
      nl_r     <= in_new_level;
      keep_r   <= in_keep_level;
      sl_r     <= in_slice_ticks;
      add_ok_r <= 1'b0;
    end else if (cmd.add) begin
      add_ok_r <= room;
    end
    if (cmd.lrd_en && cmd.lrd_sel == LR_NOW) nn_r <= !cur_ok || (cnt_s == '0);
    if (cmd.prev_cap) begin
      prev_r  <= lrd_r;
      pnone_r <= nn_r;
    end
    if (cmd.info_cap) begin
      irun_r <= trun_q;
      ilvl_r <= tlvl_q;
      isl_r  <= tsl_q;
    end
    if (!rst_n) wl_r <= '0;
    else if (cmd.wl_load) wl_r <= cmd.wl_new ? lv_new : ilvl_r;
    if (cmd.i_clr) i_r <= '0;
    else if (cmd.i_inc) i_r <= i_r + CW'(1);
  end

  assign same_task = (nn_r == pnone_r) && (nn_r || (lrd_r == prev_r));
  assign tick_disp = !same_task ||
                     ((int'(cur_r) != 1) && (int'(cur_r) < TASKS_PER_LEVEL));

  always_comb begin
    case (op_r)
      OP_SLEEP: disp = t_ok_r && irun_r && sts.prev_is_t;
      OP_TICK:  disp = tick_disp;
      default:  disp = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= nn_r;
      out_task_r   <= nn_r ? 5'd0 : 5'(lrd_r);
      out_slice_r  <= nn_r ? 8'd0 : tsl_q;
      out_disp_r   <= !nn_r && disp;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_current_task = out_task_r;
  assign out_time_slice   = out_slice_r;
  assign out_dispatch     = out_disp_r;

  always_comb begin
    sts.op        = op_r;
    sts.t_ok      = t_ok_r;
    sts.running   = irun_r;
    sts.need_rm   = need_rm;
    sts.match     = lrd_r == t_r;
    sts.scan_end  = ({1'b0, i_r} + {{CW{1'b0}}, 1'b1}) >= {1'b0, cnt_s};
    sts.n_zero    = cnt_s == '0;
    sts.sh_done   = i_r >= cnt_s;
    sts.prev_is_t = !pnone_r && (prev_r == t_r);
    sts.pending   = pend_r;
    sts.clr_last  = clr_r == TW'(NUM_TASKS - 1);
    sts.out_busy  = out_valid_r && !out_ready;
  end

  `MRR_ASSERT_NEVER(a_dp_cnt_bound, clk, rst_n, cnt_s > CW'(TASKS_PER_LEVEL), "level count above list size")
  `MRR_ASSERT(a_dp_pos_range, clk, rst_n, (cnt_s == '0) || (p0 < cnt_s), "position outside level list")
  `MRR_ASSERT(a_dp_shift_live, clk, rst_n, cmd.sh_wr |-> (i_r < cnt_s), "shift outside live entries")

endmodule
